FILE: hdl/piu_pkg.sv
// ----------------------------------------------------------------------------
// piu_pkg
// Shared types, constants and helpers for the packed index unpacker.
// ----------------------------------------------------------------------------
package piu_pkg;

    localparam int SECTION_ENTRIES_DEF = 4096;
    localparam int WORD_BITS_DEF       = 64;
    localparam int MIN_ENTRY_BITS_DEF  = 4;

    localparam int MAX_ENTRY_BITS = 16;
    localparam int EB_W           = 5;   // holds 0..MAX_ENTRY_BITS
    localparam int CFG_W          = 13;
    localparam int IDX_W          = 12;
    localparam int POS_W          = 12;
    localparam int PWORD_W        = 64;

    typedef struct packed {
        logic [PWORD_W-1:0] packed_word;
        logic               start_section;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] palette_index;
        logic [POS_W-1:0] entry_position;
        logic             last_of_word;
    } t_out_item;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic load;   // take the input word
        logic step;   // produce one entry into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic load_full;  // section already complete for the offered word
        logic last;       // current entry is the final one of the word
        logic out_free;   // output register can take a new entry
    } t_dp_stat;

    // smallest w with 2^w >= size, clamped below at min_bits
    function automatic logic [EB_W-1:0] entry_bits(input logic [CFG_W-1:0] size,
                                                   input int min_bits);
        logic [EB_W-1:0] w;
        w = '0;
        for (int i = 0; i < MAX_ENTRY_BITS; i++) begin
            if ((32'd1 << i) < 32'(size)) begin
                w = EB_W'(i + 1);
            end
        end
        if (int'(w) < min_bits) begin
            w = EB_W'(min_bits);
        end
        return w;
    endfunction

endpackage

FILE: hdl/piu_ctrl.sv
// ----------------------------------------------------------------------------
// piu_ctrl
// Sequencer: accepts a word, then steps the datapath once per entry.
// ----------------------------------------------------------------------------
module piu_ctrl import piu_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && !i_stat.load_full) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_stat.out_free && i_stat.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_RUN: begin
                o_cmd.step = i_stat.out_free;
            end
            default: ;
        endcase
    end

    // a word for a full section produces nothing and leaves us idle
    a_full_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid && i_stat.load_full) |=> r_state == ST_IDLE)
        else $error("word for full section started a run");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && o_cmd.step && i_stat.last) |=> r_state == ST_IDLE)
        else $error("run continued past last entry");

    a_no_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !o_cmd.step)
        else $error("step issued while idle");

endmodule

FILE: hdl/piu_dp.sv
// ----------------------------------------------------------------------------
// piu_dp
// Word shifter, bit offset, section counter and output register.
// ----------------------------------------------------------------------------
module piu_dp import piu_pkg::*; #(
    parameter int SECTION_ENTRIES = SECTION_ENTRIES_DEF,
    parameter int WORD_BITS       = WORD_BITS_DEF,
    parameter int MIN_ENTRY_BITS  = MIN_ENTRY_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  t_in_item         i_in,
    input  logic             i_out_ready,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    output logic             o_out_valid,
    output t_out_item        o_out
);

    localparam int CNT_W = $clog2(SECTION_ENTRIES + 1);
    localparam int OFS_W = $clog2(WORD_BITS + 2 * MAX_ENTRY_BITS + 1);
    localparam logic [CNT_W-1:0] SEC_LIMIT  = CNT_W'(SECTION_ENTRIES);
    localparam logic [OFS_W-1:0] WORD_LIMIT = OFS_W'(WORD_BITS);

    logic [EB_W-1:0]      r_entry_bits;
    logic [WORD_BITS-1:0] r_word;
    logic [OFS_W-1:0]     r_offset;
    logic [CNT_W-1:0]     r_count;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [OFS_W-1:0] w_ofs;
    logic [CNT_W-1:0] load_base;
    logic [IDX_W-1:0] idx_mask;
    t_out_item        n_out;

    assign w_ofs     = OFS_W'(r_entry_bits);
    assign load_base = i_in.start_section ? '0 : r_count;

    always_comb begin
        for (int k = 0; k < IDX_W; k++) begin
            idx_mask[k] = (k < int'(r_entry_bits));
        end
    end

    always_comb begin
        o_stat.load_full = (load_base >= SEC_LIMIT);
        // last when the following entry would not fit, or the section fills
        o_stat.last      = ((r_offset + (w_ofs << 1)) > WORD_LIMIT)
                        || ((r_count + CNT_W'(1)) >= SEC_LIMIT);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    always_comb begin
        n_out.palette_index  = r_word[IDX_W-1:0] & idx_mask;
        n_out.entry_position = POS_W'(r_count);
        n_out.last_of_word   = o_stat.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_bits <= entry_bits(CFG_W'(1), MIN_ENTRY_BITS);
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_entry_bits <= entry_bits(i_cfg_wdata, MIN_ENTRY_BITS);
            end
            if (i_cmd.load) begin
                r_count <= load_base;
            end else if (i_cmd.step) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word   <= i_in.packed_word[WORD_BITS-1:0];
            r_offset <= '0;
        end else if (i_cmd.step) begin
            r_word   <= r_word >> r_entry_bits;
            r_offset <= r_offset + w_ofs;
        end
        if (i_cmd.step) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SEC_LIMIT)
        else $error("entry count beyond section size");

    a_entry_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_offset + w_ofs) <= WORD_LIMIT)
        else $error("entry extends past end of word");

    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> o_out_valid)
        else $error("stepped entry did not reach output");

endmodule

FILE: hdl/packed_index_unpacker.sv
// ----------------------------------------------------------------------------
// packed_index_unpacker
// Unpacks fixed-width palette indices from packed words of one section.
// ----------------------------------------------------------------------------
// A word is taken while idle, then its entries leave one per cycle through
// the output register while it can take an entry (a stalled output holds the
// run), and no new word is taken until the last entry is stepped out; a word
// arriving after the section is full is taken and yields nothing. The entry
// shifter is stepped once per emitted entry. The next word can be taken while
// the final entry of the previous one still waits in the output register.
// The entry width follows palette_size when it is written.
module packed_index_unpacker import piu_pkg::*; #(
    parameter int SECTION_ENTRIES = SECTION_ENTRIES_DEF,
    parameter int WORD_BITS       = WORD_BITS_DEF,
    parameter int MIN_ENTRY_BITS  = MIN_ENTRY_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    piu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    piu_dp #(
        .SECTION_ENTRIES (SECTION_ENTRIES),
        .WORD_BITS       (WORD_BITS),
        .MIN_ENTRY_BITS  (MIN_ENTRY_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_out_ready (i_out_ready),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for packed_index_unpacker. Packed words with random
// content and random handshake gaps are sent under many palette sizes. Each
// word accepted is expanded into the expected index stream, and every output
// transfer is checked against it in order. One long section runs past the
// section end, finishing partway through a word.
// ----------------------------------------------------------------------------
module tb_top;
    import piu_pkg::*;

    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 40;
    localparam int REPORT_LIMIT  = 10;

    // Expands accepted words into expected entries and checks the output.
    class unpack_scoreboard;
        logic [CFG_W-1:0] palette_size;
        int unsigned      entries_done;
        t_out_item        entry_q[$];
        int               errors;

        function new();
            palette_size = CFG_W'(1);
            entries_done = 0;
            errors       = 0;
        endfunction

        function int width_for(logic [CFG_W-1:0] size);
            int w;
            w = 0;
            while (w < MAX_ENTRY_BITS && (32'd1 << w) < 32'(size)) w++;
            return (w < MIN_ENTRY_BITS_DEF) ? MIN_ENTRY_BITS_DEF : w;
        endfunction

        function void set_palette_size(logic [CFG_W-1:0] size);
            palette_size = size;
        endfunction

        function void note_word(t_in_item it);
            int          w;
            int          per_word;
            logic [63:0] mask;
            logic [63:0] slice;
            t_out_item   e;
            w        = width_for(palette_size);
            per_word = WORD_BITS_DEF / w;
            mask     = (64'd1 << w) - 64'd1;
            if (it.start_section) entries_done = 0;
            for (int b = 0; b < per_word; b++) begin
                if (entries_done >= SECTION_ENTRIES_DEF) break;
                slice            = (it.packed_word >> (b * w)) & mask;
                e.palette_index  = slice[IDX_W-1:0];
                e.entry_position = POS_W'(entries_done);
                // last of word: word exhausted or section just filled
                e.last_of_word   = (b == per_word - 1) ||
                                   (entries_done + 1 == SECTION_ENTRIES_DEF);
                entry_q.push_back(e);
                entries_done++;
            end
        endfunction

        function void check_entry(t_out_item got);
            t_out_item exp_e;
            if (entry_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("[%0t] unexpected transfer idx=%0d pos=%0d last=%0d", $time,
                             got.palette_index, got.entry_position, got.last_of_word);
                return;
            end
            exp_e = entry_q.pop_front();
            if (got !== exp_e) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display({"[%0t] mismatch: exp idx=%0d pos=%0d last=%0d,",
                              " got idx=%0d pos=%0d last=%0d"},
                             $time, exp_e.palette_index, exp_e.entry_position,
                             exp_e.last_of_word, got.palette_index, got.entry_position,
                             got.last_of_word);
            end
        endfunction

        function int pending();
            return entry_q.size();
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in_item         i_in;
    logic             o_out_valid;
    logic             i_out_ready;
    t_out_item        o_out;

    unpack_scoreboard sb;
    bit               calm = 1'b0;
    int               cycle_count = 0;

    packed_index_unpacker u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_entry(o_out);
    end

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] make_word();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 64'd0;
        if (r == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    // receive side stalls
    initial begin
        int g;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            g = pick_gap();
            if (g > 0) begin
                i_out_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    end

    task automatic send_word(input logic [63:0] word, input logic start);
        t_in_item it;
        int       gap;
        it.packed_word   = word;
        it.start_section = start;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(it);
    endtask

    // only while idle: all entries out, then a settle wait for a no-result word
    task automatic write_palette_size(input logic [CFG_W-1:0] size);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= size;
        @(posedge i_clk);
        sb.set_palette_size(size);
        i_cfg_we <= 1'b0;
    endtask

    // a section filled at 4-bit width up to one word short, finished at 5-bit
    // width so it ends inside a word, then a word past the end and a new section
    task automatic fill_section();
        int words;
        words = SECTION_ENTRIES_DEF / (WORD_BITS_DEF / MIN_ENTRY_BITS_DEF) - 1;
        write_palette_size(CFG_W'($urandom_range(0, 16)));
        for (int i = 0; i < words; i++) begin
            if (i > 0 && $urandom_range(0, 31) == 0)
                write_palette_size(CFG_W'($urandom_range(0, 16)));
            send_word(make_word(), i == 0);
        end
        write_palette_size(CFG_W'($urandom_range(17, 32)));
        send_word(make_word(), 1'b0);
        send_word(make_word(), 1'b0);
        send_word(make_word(), 1'b0);
        send_word(make_word(), 1'b1);
    endtask

    initial begin
        sb = new();
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset size, then width boundaries and register extremes
        send_word(64'd0, 1'b0);
        send_word('1, 1'b0);
        send_word(64'h0123_4567_89AB_CDEF, 1'b1);
        send_word(make_word(), 1'b0);
        write_palette_size(CFG_W'(0));
        send_word('1, 1'b1);
        write_palette_size(CFG_W'(16));
        send_word(64'hFEDC_BA98_7654_3210, 1'b1);
        write_palette_size(CFG_W'(17));
        send_word('1, 1'b1);
        send_word(make_word(), 1'b0);
        write_palette_size(CFG_W'(4096));
        send_word('1, 1'b1);
        send_word(make_word(), 1'b0);
        write_palette_size(CFG_W'(4097));
        send_word('1, 1'b1);
        send_word(64'h0001_0002_1000_1FFF, 1'b0);
        write_palette_size(CFG_W'(8191));
        send_word(make_word(), 1'b1);
        send_word(make_word(), 1'b0);
        write_palette_size(CFG_W'(2));
        send_word(make_word(), 1'b1);
        write_palette_size(CFG_W'(300));
        send_word('1, 1'b1);

        // full section, ending partway through a word
        calm = ($urandom_range(0, 1) == 0);
        fill_section();

        calm = 1'b0;
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/piu_pkg.sv
hdl/piu_ctrl.sv
hdl/piu_dp.sv
hdl/packed_index_unpacker.sv
verif/tb_top.sv
